### rtl/assert_macros.svh
// assertion macros used by the rtl sequencer top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### rtl/lcdseq_pkg.sv
// shared types, codes and constants of the character lcd bus sequencer
package lcdseq_pkg;

    localparam int MAX_XFERS = 12;
    localparam int IDX_W     = $clog2(MAX_XFERS);

    // operation codes
    localparam logic [3:0] ACT_INIT    = 4'd0;
    localparam logic [3:0] ACT_COMMAND = 4'd1;
    localparam logic [3:0] ACT_DATA    = 4'd2;
    localparam logic [3:0] ACT_CURSOR  = 4'd3;
    localparam logic [3:0] ACT_CLEAR   = 4'd4;
    localparam logic [3:0] ACT_HOME    = 4'd5;
    localparam logic [3:0] ACT_DISPLAY = 4'd6;
    localparam logic [3:0] ACT_ENTRY   = 4'd7;
    localparam logic [3:0] ACT_SCROLL  = 4'd8;
    localparam logic [3:0] ACT_GLYPH   = 4'd9;

    // configuration register indexes
    localparam logic [2:0] REG_EIGHT_BIT  = 3'd0;
    localparam logic [2:0] REG_LINE_COUNT = 3'd1;
    localparam logic [2:0] REG_DISPLAY_ON = 3'd2;
    localparam logic [2:0] REG_CURSOR_ON  = 3'd3;
    localparam logic [2:0] REG_BLINK_ON   = 3'd4;
    localparam logic [2:0] REG_AUTOSCROLL = 3'd5;

    // controller command bytes
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_DISPLAY   = 8'h08;
    localparam logic [7:0] CMD_DISP_INIT = 8'h0C;
    localparam logic [7:0] CMD_SHIFT_L   = 8'h18;
    localparam logic [7:0] CMD_SHIFT_R   = 8'h1C;
    localparam logic [7:0] CMD_FUNC      = 8'h20;
    localparam logic [7:0] FUNC_8BIT     = 8'h10;
    localparam logic [7:0] FUNC_2LINE    = 8'h08;
    localparam logic [7:0] CMD_CGRAM     = 8'h40;
    localparam logic [7:0] CMD_DDRAM     = 8'h80;
    localparam logic [7:0] NIB_WAKE      = 8'h03;
    localparam logic [7:0] NIB_4BIT      = 8'h02;

    typedef struct packed {
        logic       eight_bit_bus;
        logic [2:0] line_count;
        logic       display_on;
        logic       cursor_on;
        logic       blink_on;
        logic       autoscroll;
    } t_cfg;

    typedef struct packed {
        logic       register_select;
        logic [7:0] bus_value;
        logic       power_up_wait;
        logic       wait_after;
        logic       last_transfer;
    } t_xfer;

    // ddram start address of each display row
    function automatic logic [6:0] row_base(input logic [1:0] row);
        logic [6:0] base;
        case (row)
            2'd0:    base = 7'h00;
            2'd1:    base = 7'h40;
            2'd2:    base = 7'h14;
            default: base = 7'h54;
        endcase
        return base;
    endfunction

endpackage

### rtl/lcdseq_cfg.sv
// configuration register file of the lcd bus sequencer
module lcdseq_cfg import lcdseq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [2:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eight_bit_bus <= 1'b0;
            r_cfg.line_count    <= 3'd1;
            r_cfg.display_on    <= 1'b1;
            r_cfg.cursor_on     <= 1'b0;
            r_cfg.blink_on      <= 1'b0;
            r_cfg.autoscroll    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_EIGHT_BIT:  r_cfg.eight_bit_bus <= i_cfg_data[0];
                REG_LINE_COUNT: r_cfg.line_count    <= i_cfg_data;
                REG_DISPLAY_ON: r_cfg.display_on    <= i_cfg_data[0];
                REG_CURSOR_ON:  r_cfg.cursor_on     <= i_cfg_data[0];
                REG_BLINK_ON:   r_cfg.blink_on      <= i_cfg_data[0];
                REG_AUTOSCROLL: r_cfg.autoscroll    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/lcdseq_xfer.sv
// builds transfer number idx of one lcd operation
module lcdseq_xfer import lcdseq_pkg::*; (
    input  t_cfg             i_cfg,
    input  logic [3:0]       i_action,
    input  logic [7:0]       i_value,
    input  logic [6:0]       i_column,
    input  logic [7:0]       i_row,
    input  logic             i_scroll_left,
    input  logic [IDX_W-1:0] i_idx,
    output t_xfer            o_xfer
);

    always_comb begin
        logic [1:0]       max_row;
        logic [1:0]       row_sel;
        logic [6:0]       addr;
        logic [7:0]       func_set;
        logic [7:0]       cmd;
        logic             rs;
        logic             long_wait;
        logic             is_raw;
        logic [7:0]       raw_val;
        logic             raw_long;
        logic             half;
        logic             is_last;
        logic [IDX_W-1:0] off;
        logic [1:0]       step;

        case (i_cfg.line_count)
            3'd0, 3'd1: max_row = 2'd0;
            3'd2:       max_row = 2'd1;
            3'd3:       max_row = 2'd2;
            default:    max_row = 2'd3;
        endcase
        row_sel = (i_row > {6'd0, max_row}) ? max_row : i_row[1:0];
        addr    = i_column + row_base(row_sel);

        func_set = CMD_FUNC
                 | (i_cfg.eight_bit_bus ? FUNC_8BIT : 8'h00)
                 | ((i_cfg.line_count > 3'd1) ? FUNC_2LINE : 8'h00);

        rs        = 1'b0;
        long_wait = 1'b0;
        is_raw    = 1'b0;
        raw_val   = NIB_WAKE;
        raw_long  = 1'b0;
        half      = i_idx[0];
        is_last   = 1'b1;
        off       = '0;
        step      = 2'd0;
        cmd       = i_value;

        case (i_action)
            ACT_INIT: begin
                // wake-up preamble first, then four setup bytes
                if (i_cfg.eight_bit_bus) begin
                    is_raw   = (i_idx < IDX_W'(3));
                    raw_val  = func_set;
                    raw_long = (i_idx != IDX_W'(2));
                    off      = i_idx - IDX_W'(3);
                    step     = off[1:0];
                end else begin
                    is_raw   = (i_idx < IDX_W'(4));
                    raw_val  = (i_idx == IDX_W'(3)) ? NIB_4BIT : NIB_WAKE;
                    raw_long = (i_idx != IDX_W'(3));
                    off      = i_idx - IDX_W'(4);
                    step     = off[2:1];
                end
                case (step)
                    2'd0:    cmd = func_set;
                    2'd1:    cmd = CMD_DISP_INIT;
                    2'd2: begin
                        cmd       = CMD_CLEAR;
                        long_wait = 1'b1;
                    end
                    default: cmd = CMD_ENTRY;
                endcase
                is_last = (step == 2'd3);
            end
            ACT_COMMAND: cmd = i_value;
            ACT_DATA: begin
                cmd = i_value;
                rs  = 1'b1;
            end
            ACT_CURSOR:  cmd = CMD_DDRAM | {1'b0, addr};
            ACT_CLEAR: begin
                cmd       = CMD_CLEAR;
                long_wait = 1'b1;
            end
            ACT_HOME: begin
                cmd       = CMD_HOME;
                long_wait = 1'b1;
            end
            ACT_DISPLAY: cmd = CMD_DISPLAY | {5'd0, i_cfg.display_on,
                                              i_cfg.cursor_on, i_cfg.blink_on};
            ACT_ENTRY:   cmd = CMD_ENTRY | {7'd0, i_cfg.autoscroll};
            ACT_SCROLL:  cmd = i_scroll_left ? CMD_SHIFT_L : CMD_SHIFT_R;
            ACT_GLYPH:   cmd = CMD_CGRAM | {2'd0, i_value[2:0], 3'd0};
            default:     cmd = i_value;
        endcase

        o_xfer.register_select = rs;
        if (is_raw) begin
            o_xfer.bus_value     = raw_val;
            o_xfer.power_up_wait = (i_idx == '0);
            o_xfer.wait_after    = raw_long;
            o_xfer.last_transfer = 1'b0;
        end else if (i_cfg.eight_bit_bus) begin
            o_xfer.bus_value     = cmd;
            o_xfer.power_up_wait = 1'b0;
            o_xfer.wait_after    = long_wait;
            o_xfer.last_transfer = is_last;
        end else begin
            // high nibble on the even transfer, low nibble carries the wait
            o_xfer.bus_value     = half ? {4'd0, cmd[3:0]} : {4'd0, cmd[7:4]};
            o_xfer.power_up_wait = 1'b0;
            o_xfer.wait_after    = half & long_wait;
            o_xfer.last_transfer = half & is_last;
        end
    end

endmodule

### rtl/character_lcd_bus_sequencer.sv
// Character LCD bus sequencer: expands one LCD operation into controller bus words.
//
// Input channel (i_valid / o_stall) takes one operation word; the output channel
// (o_valid / i_stall) gives one bus transfer per word, the last one of an operation
// marked by o_last_transfer. The config port (i_cfg_we, i_cfg_index, i_cfg_data)
// writes a register; the user must use it only while the block is idle, which the
// block itself does not enforce. The first transfer of an operation is valid once
// the operation has passed the operation register and the output register; this
// single output register then gives one transfer per cycle while the receiver does
// not stall. An operation makes 1 to 12 transfers (init is 12 on a nibble bus and 7
// on a byte bus, other operations 1 or 2, unused codes take no transfer and are
// dropped on acceptance). The next operation is accepted in the cycle the last
// transfer of the current one moves to the output register. When the receiver
// stalls, the output register and the transfer counter hold, and o_stall rises on
// the input side if an operation waits. Reset empties both stages and loads the
// register defaults (nibble bus, one line, display on).
`include "assert_macros.svh"

module character_lcd_bus_sequencer import lcdseq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [2:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [3:0] i_action,
    input  logic [7:0] i_value,
    input  logic [6:0] i_column,
    input  logic [7:0] i_row,
    input  logic       i_scroll_left,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_register_select,
    output logic [7:0] o_bus_value,
    output logic       o_power_up_wait,
    output logic       o_wait_after,
    output logic       o_last_transfer
);

    t_cfg             cfg;
    t_xfer            xfer;

    logic             r_a_valid;
    logic [IDX_W-1:0] r_a_idx;
    logic [3:0]       r_action;
    logic [7:0]       r_value;
    logic [6:0]       r_column;
    logic [7:0]       r_row;
    logic             r_scroll_left;
    logic             r_o_valid;
    t_xfer            r_out;

    logic             advance;
    logic             finish;
    logic             accept;

    lcdseq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    lcdseq_xfer u_xfer (
        .i_cfg         (cfg),
        .i_action      (r_action),
        .i_value       (r_value),
        .i_column      (r_column),
        .i_row         (r_row),
        .i_scroll_left (r_scroll_left),
        .i_idx         (r_a_idx),
        .o_xfer        (xfer)
    );

    assign advance = !r_o_valid || !i_stall;
    assign finish  = r_a_valid && advance && xfer.last_transfer;
    assign o_stall = r_a_valid && !finish;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_idx   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (accept) begin
                // unused codes produce nothing, so they never occupy the stage
                r_a_valid <= (i_action <= ACT_GLYPH);
                r_a_idx   <= '0;
            end else if (finish) begin
                r_a_valid <= 1'b0;
                r_a_idx   <= '0;
            end else if (r_a_valid && advance) begin
                r_a_idx <= r_a_idx + IDX_W'(1);
            end
            if (advance) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action      <= i_action;
            r_value       <= i_value;
            r_column      <= i_column;
            r_row         <= i_row;
            r_scroll_left <= i_scroll_left;
        end
        if (advance && r_a_valid) begin
            r_out <= xfer;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_register_select = r_out.register_select;
    assign o_bus_value       = r_out.bus_value;
    assign o_power_up_wait   = r_out.power_up_wait;
    assign o_wait_after      = r_out.wait_after;
    assign o_last_transfer   = r_out.last_transfer;

    `ASSERT_CLK(a_idx_range, i_clk, i_rst_n, r_a_valid |-> (r_a_idx < IDX_W'(MAX_XFERS)))
    `ASSERT_CLK(a_idle_idx_zero, i_clk, i_rst_n, !r_a_valid |-> (r_a_idx == '0))
    `ASSERT_CLK(a_hold_on_stall, i_clk, i_rst_n, (r_o_valid && i_stall) |=> $stable(r_a_idx))
    `ASSERT_NEVER(a_pwr_on_data, i_clk, i_rst_n,
                  o_valid && o_power_up_wait && (o_register_select || !o_wait_after))

endmodule

### test/tb_character_lcd_bus_sequencer.sv
// testbench for the character lcd bus sequencer: directed table, then random operations
`timescale 1ns / 100ps

module tb_character_lcd_bus_sequencer;
    import lcdseq_pkg::*;

    // operation codes the block drops without a transfer
    localparam logic [3:0] ACT_SPARE_FIRST = 4'd10;
    localparam logic [3:0] ACT_SPARE_LAST  = 4'd15;
    // register indexes with no register behind them
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int OPS_PER_PHASE = 50;

    localparam logic [6:0] ROW_START [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

    typedef struct packed {
        logic [3:0] act;
        logic [7:0] val;
        logic [6:0] col;
        logic [7:0] rw;
        logic       left;
        logic       typed;
        logic       rs;
        logic [7:0] cmd_byte;
        logic       longw;
    } t_dir_row;

    // typed rows hold the byte expected under reset settings (nibble bus, one line)
    localparam t_dir_row DIRECTED [21] = '{
        '{ACT_INIT,    8'h00, 7'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ACT_COMMAND, 8'h00, 7'h00, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0},
        '{ACT_COMMAND, 8'hFF, 7'h7F, 8'hFF, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b0},
        '{ACT_DATA,    8'h00, 7'h00, 8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0},
        '{ACT_DATA,    8'hFF, 7'h00, 8'h00, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b0},
        '{ACT_DATA,    8'h5A, 7'h2A, 8'h55, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ACT_CURSOR,  8'h00, 7'h00, 8'h00, 1'b0, 1'b1, 1'b0, 8'h80, 1'b0},
        '{ACT_CURSOR,  8'hFF, 7'h7F, 8'hFF, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b0},
        '{ACT_CURSOR,  8'h00, 7'd100, 8'd1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ACT_CLEAR,   8'h00, 7'h00, 8'h00, 1'b0, 1'b1, 1'b0, 8'h01, 1'b1},
        '{ACT_HOME,    8'h00, 7'h00, 8'h00, 1'b0, 1'b1, 1'b0, 8'h02, 1'b1},
        '{ACT_DISPLAY, 8'h00, 7'h00, 8'h00, 1'b0, 1'b1, 1'b0, 8'h0C, 1'b0},
        '{ACT_ENTRY,   8'h00, 7'h00, 8'h00, 1'b0, 1'b1, 1'b0, 8'h06, 1'b0},
        '{ACT_SCROLL,  8'h00, 7'h00, 8'h00, 1'b1, 1'b1, 1'b0, 8'h18, 1'b0},
        '{ACT_SCROLL,  8'h00, 7'h00, 8'h00, 1'b0, 1'b1, 1'b0, 8'h1C, 1'b0},
        '{ACT_GLYPH,   8'hFF, 7'h00, 8'h00, 1'b0, 1'b1, 1'b0, 8'h78, 1'b0},
        '{ACT_GLYPH,   8'h00, 7'h00, 8'h00, 1'b0, 1'b1, 1'b0, 8'h40, 1'b0},
        '{ACT_GLYPH,   8'hA3, 7'h11, 8'h02, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ACT_SPARE_FIRST, 8'h12, 7'h05, 8'h01, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ACT_SPARE_LAST,  8'h34, 7'h06, 8'h02, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ACT_COMMAND, 8'h3C, 7'h00, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}
    };

    typedef struct packed {
        logic       eight;
        logic [2:0] lines;
        logic       disp;
        logic       cur;
        logic       blink;
        logic       auto_shift;
        logic       calm;
    } t_phase;

    // line counts 0, 5 and 7 hit the clamp corners
    localparam t_phase PHASES [8] = '{
        '{1'b1, 3'd4, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0},
        '{1'b0, 3'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b1, 3'd7, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0},
        '{1'b0, 3'd2, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1},
        '{1'b1, 3'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 3'd5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0},
        '{1'b0, 3'd3, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{1'b1, 3'd4, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [2:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [3:0] i_action = '0;
    logic [7:0] i_value = '0;
    logic [6:0] i_column = '0;
    logic [7:0] i_row = '0;
    logic       i_scroll_left = 1'b0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_register_select;
    logic [7:0] o_bus_value;
    logic       o_power_up_wait;
    logic       o_wait_after;
    logic       o_last_transfer;

    // expectation typed into the table travels with the word it belongs to
    logic       typed_row = 1'b0;
    logic       typed_rs = 1'b0;
    logic [7:0] typed_byte = '0;
    logic       typed_long = 1'b0;

    t_cfg   lcd_cfg;
    t_xfer  pending_xfers[$];
    int     mismatches = 0;
    int     cycles = 0;
    int     gap_pct = 14;
    int     stall_pct = 14;

    character_lcd_bus_sequencer DUT (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d transfers outstanding", pending_xfers.size());
            $display("tb_character_lcd_bus_sequencer failed");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    function automatic void add_xfer(input logic rs, input logic [7:0] bus,
                                     input logic pwr, input logic longw);
        t_xfer x;
        x.register_select = rs;
        x.bus_value = bus;
        x.power_up_wait = pwr;
        x.wait_after = longw;
        x.last_transfer = 1'b0;
        pending_xfers.push_back(x);
    endfunction

    // long wait goes with the low nibble on a nibble bus
    function automatic void add_byte(input logic rs, input logic [7:0] b, input logic longw);
        if (lcd_cfg.eight_bit_bus) begin
            add_xfer(rs, b, 1'b0, longw);
        end else begin
            add_xfer(rs, {4'h0, b[7:4]}, 1'b0, 1'b0);
            add_xfer(rs, {4'h0, b[3:0]}, 1'b0, longw);
        end
    endfunction

    function automatic void predict_transfers(input logic [3:0] act, input logic [7:0] val,
                                              input logic [6:0] col, input logic [7:0] rw,
                                              input logic left, input logic typed,
                                              input logic t_rs, input logic [7:0] t_byte,
                                              input logic t_long);
        int         start_size;
        int         max_row;
        logic [7:0] fset;
        logic [1:0] row_sel;
        logic [6:0] addr;
        t_xfer      tail;
        start_size = pending_xfers.size();
        fset = CMD_FUNC | (lcd_cfg.eight_bit_bus ? FUNC_8BIT : 8'h00)
                        | ((lcd_cfg.line_count > 3'd1) ? FUNC_2LINE : 8'h00);
        if (typed) begin
            add_byte(t_rs, t_byte, t_long);
        end else begin
            case (act)
                ACT_INIT: begin
                    if (lcd_cfg.eight_bit_bus) begin
                        add_xfer(1'b0, fset, 1'b1, 1'b1);
                        add_xfer(1'b0, fset, 1'b0, 1'b1);
                        add_xfer(1'b0, fset, 1'b0, 1'b0);
                    end else begin
                        add_xfer(1'b0, NIB_WAKE, 1'b1, 1'b1);
                        add_xfer(1'b0, NIB_WAKE, 1'b0, 1'b1);
                        add_xfer(1'b0, NIB_WAKE, 1'b0, 1'b1);
                        add_xfer(1'b0, NIB_4BIT, 1'b0, 1'b0);
                    end
                    add_byte(1'b0, fset, 1'b0);
                    add_byte(1'b0, CMD_DISP_INIT, 1'b0);
                    add_byte(1'b0, CMD_CLEAR, 1'b1);
                    add_byte(1'b0, CMD_ENTRY, 1'b0);
                end
                ACT_COMMAND: add_byte(1'b0, val, 1'b0);
                ACT_DATA:    add_byte(1'b1, val, 1'b0);
                ACT_CURSOR: begin
                    // zero lines acts as one, more than four as four
                    max_row = int'(lcd_cfg.line_count);
                    if (max_row == 0) max_row = 1;
                    if (max_row > 4) max_row = 4;
                    max_row = max_row - 1;
                    row_sel = (int'(rw) > max_row) ? 2'(max_row) : rw[1:0];
                    addr = col + ROW_START[row_sel];
                    add_byte(1'b0, CMD_DDRAM | {1'b0, addr}, 1'b0);
                end
                ACT_CLEAR:   add_byte(1'b0, CMD_CLEAR, 1'b1);
                ACT_HOME:    add_byte(1'b0, CMD_HOME, 1'b1);
                ACT_DISPLAY: add_byte(1'b0, CMD_DISPLAY | {5'b0, lcd_cfg.display_on,
                                      lcd_cfg.cursor_on, lcd_cfg.blink_on}, 1'b0);
                ACT_ENTRY:   add_byte(1'b0, CMD_ENTRY | {7'b0, lcd_cfg.autoscroll}, 1'b0);
                ACT_SCROLL:  add_byte(1'b0, left ? CMD_SHIFT_L : CMD_SHIFT_R, 1'b0);
                ACT_GLYPH:   add_byte(1'b0, CMD_CGRAM | {2'b0, val[2:0], 3'b0}, 1'b0);
                default: ;
            endcase
        end
        if (pending_xfers.size() > start_size) begin
            tail = pending_xfers.pop_back();
            tail.last_transfer = 1'b1;
            pending_xfers.push_back(tail);
        end
    endfunction

    // outputs checked before the accepted word is predicted: its transfers come later
    always @(posedge i_clk) begin : monitor
        t_xfer want;
        if (!i_rst_n) begin
            lcd_cfg.eight_bit_bus <= 1'b0;
            lcd_cfg.line_count <= 3'd1;
            lcd_cfg.display_on <= 1'b1;
            lcd_cfg.cursor_on <= 1'b0;
            lcd_cfg.blink_on <= 1'b0;
            lcd_cfg.autoscroll <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_xfers.size() == 0) begin
                    flag_mismatch($sformatf("transfer rs=%0b bus=%02h with nothing expected",
                                            o_register_select, o_bus_value));
                end else begin
                    want = pending_xfers.pop_front();
                    if (o_register_select !== want.register_select)
                        flag_mismatch($sformatf("register_select %0b, expected %0b",
                                                o_register_select, want.register_select));
                    if (o_bus_value !== want.bus_value)
                        flag_mismatch($sformatf("bus_value %02h, expected %02h",
                                                o_bus_value, want.bus_value));
                    if (o_power_up_wait !== want.power_up_wait)
                        flag_mismatch($sformatf("power_up_wait %0b, expected %0b",
                                                o_power_up_wait, want.power_up_wait));
                    if (o_wait_after !== want.wait_after)
                        flag_mismatch($sformatf("wait_after %0b, expected %0b",
                                                o_wait_after, want.wait_after));
                    if (o_last_transfer !== want.last_transfer)
                        flag_mismatch($sformatf("last_transfer %0b, expected %0b",
                                                o_last_transfer, want.last_transfer));
                end
            end
            if (i_valid && !o_stall)
                predict_transfers(i_action, i_value, i_column, i_row, i_scroll_left,
                                  typed_row, typed_rs, typed_byte, typed_long);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_EIGHT_BIT:  lcd_cfg.eight_bit_bus <= i_cfg_data[0];
                    REG_LINE_COUNT: lcd_cfg.line_count <= i_cfg_data;
                    REG_DISPLAY_ON: lcd_cfg.display_on <= i_cfg_data[0];
                    REG_CURSOR_ON:  lcd_cfg.cursor_on <= i_cfg_data[0];
                    REG_BLINK_ON:   lcd_cfg.blink_on <= i_cfg_data[0];
                    REG_AUTOSCROLL: lcd_cfg.autoscroll <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // called right after a rising edge; returns at the edge the word is taken
    task automatic send_op(input logic [3:0] act, input logic [7:0] val, input logic [6:0] col,
                           input logic [7:0] rw, input logic left, input logic typed,
                           input logic t_rs, input logic [7:0] t_byte, input logic t_long);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_value <= val;
        i_column <= col;
        i_row <= rw;
        i_scroll_left <= left;
        typed_row <= typed;
        typed_rs <= t_rs;
        typed_byte <= t_byte;
        typed_long <= t_long;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_xfers.size() != 0) @(posedge i_clk);
        // a dropped code may still be in flight
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [2:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // upper data bits of one-bit registers are don't-care, so they go random
    task automatic load_settings(input t_phase p);
        write_reg(REG_EIGHT_BIT, {2'($urandom_range(0, 3)), p.eight});
        write_reg(REG_LINE_COUNT, p.lines);
        write_reg(REG_DISPLAY_ON, {2'($urandom_range(0, 3)), p.disp});
        write_reg(REG_CURSOR_ON, {2'($urandom_range(0, 3)), p.cur});
        write_reg(REG_BLINK_ON, {2'($urandom_range(0, 3)), p.blink});
        write_reg(REG_AUTOSCROLL, {2'($urandom_range(0, 3)), p.auto_shift});
        write_reg(REG_SPARE_LO, 3'($urandom_range(0, 7)));
        write_reg(REG_SPARE_HI, 3'($urandom_range(0, 7)));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random_ops(input int count);
        int         done_ops;
        int         pick;
        logic [3:0] act;
        logic [7:0] rw;
        done_ops = 0;
        while (done_ops < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                act = ACT_INIT;
            end else if (pick < 92) begin
                // cursor weighted double, it carries the row clamp
                pick = $urandom_range(1, 10);
                act = (pick == 10) ? ACT_CURSOR : 4'(pick);
            end else begin
                act = 4'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
            end
            rw = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 6));
            send_op(act, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)), rw,
                    1'($urandom_range(0, 1)), 1'b0, 1'b0, 8'h00, 1'b0);
            if (act <= ACT_GLYPH) done_ops++;
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (DIRECTED[k])
            send_op(DIRECTED[k].act, DIRECTED[k].val, DIRECTED[k].col, DIRECTED[k].rw,
                    DIRECTED[k].left, DIRECTED[k].typed, DIRECTED[k].rs,
                    DIRECTED[k].cmd_byte, DIRECTED[k].longw);
        foreach (PHASES[p]) begin
            wait_idle();
            load_settings(PHASES[p]);
            gap_pct = PHASES[p].calm ? 0 : 14;
            stall_pct = PHASES[p].calm ? 0 : 14;
            run_random_ops(OPS_PER_PHASE);
        end
        stall_pct = 14;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_character_lcd_bus_sequencer passed");
        end else begin
            $display("tb_character_lcd_bus_sequencer failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/lcdseq_pkg.sv
rtl/lcdseq_cfg.sv
rtl/lcdseq_xfer.sv
rtl/character_lcd_bus_sequencer.sv
test/tb_character_lcd_bus_sequencer.sv
